// ===== hw/rtl/nps_pkg.sv =====
`timescale 1ns / 1ps

package nps_pkg;

	// Parse phase of the start-code scanner.
	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_HEADER = 2'd1,
		PH_UNIT   = 2'd2
	} phase_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_CODEC_KIND = 1'b0,
		REG_KEEP_PS    = 1'b1
	} reg_idx_t;

	localparam logic [1:0] CODEC_H264 = 2'd0;
	localparam logic [1:0] CODEC_H265 = 2'd1;

	localparam logic [4:0] H264_SPS = 5'd7;
	localparam logic [4:0] H264_PPS = 5'd8;
	localparam logic [5:0] H265_VPS = 6'd32;
	localparam logic [5:0] H265_SPS = 6'd33;
	localparam logic [5:0] H265_PPS = 6'd34;

	// One classified byte: a prefix of zero bytes (a start code when pre_sc,
	// ending in 01), then an optional tail byte; last closes the buffer.
	typedef struct packed {
		logic [2:0] pre_len;
		logic       pre_sc;
		logic       tail_vld;
		logic [7:0] tail_byte;
		logic       last;
	} cmd_t;

	function automatic logic is_param_set(input logic [1:0] codec, input logic [7:0] hdr);
		logic [4:0] t264;
		logic [5:0] t265;
		t264 = hdr[4:0];
		t265 = hdr[6:1];
		case (codec)
			CODEC_H264: is_param_set = (t264 == H264_SPS) || (t264 == H264_PPS);
			CODEC_H265: is_param_set = (t265 == H265_VPS) || (t265 == H265_SPS) ||
			                           (t265 == H265_PPS);
			default:    is_param_set = 1'b0;
		endcase
	endfunction

endpackage

// ===== hw/rtl/nps_front.sv =====
`timescale 1ns / 1ps

module nps_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [1:0]       cfg_wdata,
	input  logic             in_vld,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic             q_ready,
	output logic             push,
	output nps_pkg::cmd_t    cmd
);

	logic [1:0]       codec_q;
	logic             kps_q;
	nps_pkg::phase_t  phase_q, phase_d;
	logic [1:0]       held_q, held_d;
	logic             sc4_q, sc4_d;
	logic             keep_q, keep_d;

	logic accept;
	logic is_zero, is_sc, keep_hdr, pass;

	assign accept   = in_vld && q_ready;
	assign is_zero  = (in_byte == 8'h00) && !in_last;
	assign is_sc    = (in_byte == 8'h01) && held_q[1] && !in_last;
	assign keep_hdr = kps_q ? nps_pkg::is_param_set(codec_q, in_byte)
	                        : !nps_pkg::is_param_set(codec_q, in_byte);
	assign pass     = (phase_q == nps_pkg::PH_UNIT) && keep_q;

	// Next state.
	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		sc4_d   = sc4_q;
		keep_d  = keep_q;
		if (phase_q == nps_pkg::PH_HEADER) begin
			keep_d  = keep_hdr;
			held_d  = 2'd0;
			phase_d = nps_pkg::PH_UNIT;
		end else if (is_zero) begin
			held_d = (held_q == 2'd3) ? 2'd3 : held_q + 2'd1;
		end else if (is_sc) begin
			sc4_d   = (held_q == 2'd3);
			held_d  = 2'd0;
			phase_d = nps_pkg::PH_HEADER;
		end else begin
			held_d = 2'd0;
		end
		if (in_last) begin
			phase_d = nps_pkg::PH_SEARCH;
			held_d  = 2'd0;
			sc4_d   = 1'b0;
			keep_d  = 1'b0;
		end
	end

	// Command toward the back end.
	always_comb begin
		cmd           = '0;
		cmd.tail_byte = in_byte;
		cmd.last      = in_last;
		if (phase_q == nps_pkg::PH_HEADER) begin
			if (keep_hdr) begin
				cmd.pre_len  = sc4_q ? 3'd4 : 3'd3;
				cmd.pre_sc   = 1'b1;
				cmd.tail_vld = 1'b1;
			end
		end else if (is_zero) begin
			if (held_q == 2'd3 && pass)
				cmd.pre_len = 3'd1;
		end else if (!is_sc) begin
			if (pass) begin
				cmd.pre_len  = {1'b0, held_q};
				cmd.tail_vld = 1'b1;
			end
		end
	end

	assign push = accept && ((cmd.pre_len != 3'd0) || cmd.tail_vld || cmd.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_q <= 2'd0;
			kps_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				nps_pkg::REG_CODEC_KIND: codec_q <= cfg_wdata;
				nps_pkg::REG_KEEP_PS:    kps_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nps_pkg::PH_SEARCH;
			held_q  <= 2'd0;
			sc4_q   <= 1'b0;
			keep_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			sc4_q   <= sc4_d;
			keep_q  <= keep_d;
		end
	end

endmodule

// ===== hw/rtl/nps_queue.sv =====
`timescale 1ns / 1ps

module nps_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nps_pkg::cmd_t wr_cmd,
	input  logic          pop,
	output logic          ready,
	output logic          head_vld,
	output nps_pkg::cmd_t head
);

	nps_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;

	assign ready    = (count_q != 2'd2);
	assign head_vld = (count_q != 2'd0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/nps_back.sv =====
`timescale 1ns / 1ps

module nps_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_vld,
	input  nps_pkg::cmd_t head,
	output logic          pop,
	input  logic          out_ready,
	output logic          out_vld,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic          unit_first,
	output logic          buffer_end,
	output logic          run_last
);

	logic [2:0] idx_q;
	logic       vld_q;
	logic [7:0] byte_q;
	logic       bv_q, first_q, end_q, rl_q;

	logic [2:0] total;
	logic       marker, final_res, load, in_pre;
	logic [7:0] res_byte;

	assign total     = head.pre_len + {2'b00, head.tail_vld};
	assign marker    = (total == 3'd0);
	assign final_res = marker || (idx_q == total - 3'd1);
	assign in_pre    = (idx_q < head.pre_len);
	assign load      = head_vld && (!vld_q || out_ready);
	assign pop       = load && final_res;

	always_comb begin
		if (marker)
			res_byte = 8'h00;
		else if (in_pre)
			res_byte = (head.pre_sc && idx_q == head.pre_len - 3'd1) ? 8'h01 : 8'h00;
		else
			res_byte = head.tail_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
			vld_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= final_res ? 3'd0 : idx_q + 3'd1;
			if (load)
				vld_q <= 1'b1;
			else if (out_ready)
				vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= res_byte;
			bv_q    <= !marker;
			first_q <= !marker && head.pre_sc && (idx_q == 3'd0);
			end_q   <= head.last && final_res;
			rl_q    <= final_res;
		end
	end

	assign out_vld    = vld_q;
	assign out_byte   = byte_q;
	assign byte_valid = bv_q;
	assign unit_first = first_q;
	assign buffer_end = end_q;
	assign run_last   = rl_q;

endmodule

// ===== hw/rtl/nal_parameter_set_filter.sv =====
`timescale 1ns / 1ps

// Annex B parameter-set filter. Bytes of a coded buffer enter one per
// transaction on the s_axis side, tlast marking the buffer's final byte.
// Start codes (00 00 01 or 00 00 00 01) followed by at least one byte of the
// same buffer split it into units; bytes before the first such start code are
// dropped. The header byte after the start code decides, with the registers
// as they stand then, whether the whole unit is kept: parameter sets (H.264
// types 7 and 8, H.265 types 32 to 34, none for codec_kind 2 or 3) pass
// alone when keep_parameter_sets is 1, and everything else passes when it
// is 0. Kept units leave on the m_axis side behind their own 3- or 4-byte
// start code, unit_first marking its first byte. Every input byte that yields
// results has run_last on its last one; the buffer's final result has tlast,
// and a bare end marker (byte_valid 0) is sent if the final byte yields
// nothing. Rate: one byte per cycle in and out while the output is ready and
// each byte gives at most one result; a kept header byte gives 4 or 5 results
// and a data byte behind held zeros gives up to 4 (the zeros, then itself),
// and the back-end expander sends one result per cycle while the output is
// ready. A two-entry queue between the classifier and the expander takes up
// short stalls on either side. With the queue empty and the output free, the
// first result of a byte is stored in the queue and then registered by the
// expander before it is valid. Write configuration only while the block is
// idle.
module nal_parameter_set_filter (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_wdata,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // buffer_last
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] run_last, rest zero
	output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] unit_first
	output logic        m_axis_tlast    // buffer_end
);

	nps_pkg::cmd_t front_cmd, head;
	logic          push, q_ready, head_vld, pop;
	logic [7:0]    out_byte;
	logic          byte_valid, unit_first, buffer_end, run_last;

	// Front: scan for start codes, classify headers, decide what each byte emits.
	nps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_vld    (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.q_ready   (q_ready),
		.push      (push),
		.cmd       (front_cmd)
	);

	assign s_axis_tready = q_ready;

	// Queue: decouple the classifier from the expander.
	nps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_cmd   (front_cmd),
		.pop      (pop),
		.ready    (q_ready),
		.head_vld (head_vld),
		.head     (head)
	);

	// Back: expand each command into result transactions, one per cycle while the output is ready.
	nps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_vld   (head_vld),
		.head       (head),
		.pop        (pop),
		.out_ready  (m_axis_tready),
		.out_vld    (m_axis_tvalid),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.unit_first (unit_first),
		.buffer_end (buffer_end),
		.run_last   (run_last)
	);

	assign m_axis_tdata = {7'd0, run_last, out_byte};
	assign m_axis_tuser = {unit_first, byte_valid};
	assign m_axis_tlast = buffer_end;

	// A bare end marker only closes a buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata[8]))
		else $error("bare marker without buffer end");

	// The first byte of a kept unit is the zero opening its start code.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |->
		(m_axis_tuser[0] && m_axis_tdata[7:0] == 8'h00 && !m_axis_tdata[8]))
		else $error("unit_first on a non start-code byte");

	// The buffer's final result is always the last one of its input byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[8])
		else $error("buffer end before run end");

	// A popped command was present in the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_vld)
		else $error("queue underflow");

endmodule
